// ===== rtl/fdc_pkg.sv =====
package fdc_pkg;

	// Default sizes of the sector buffer, the disk image and the drive count.
	localparam int SECTOR_BYTES_DEF = 1024;
	localparam int DISK_BYTES_DEF   = 819200;
	localparam int DRIVES_DEF       = 4;

	// Bytes cleared by a format when no image is mounted.
	localparam int BLANK_BYTES = 'hA00 * 'h100;

	// Bus access codes.
	localparam logic [3:0] OP_RD_STATUS = 4'd0;
	localparam logic [3:0] OP_WR_CMD    = 4'd1;
	localparam logic [3:0] OP_RD_TRACK  = 4'd2;
	localparam logic [3:0] OP_WR_TRACK  = 4'd3;
	localparam logic [3:0] OP_RD_SECTOR = 4'd4;
	localparam logic [3:0] OP_WR_SECTOR = 4'd5;
	localparam logic [3:0] OP_RD_DATA   = 4'd6;
	localparam logic [3:0] OP_WR_DATA   = 4'd7;
	localparam logic [3:0] OP_RD_IRQ    = 4'd8;
	localparam logic [3:0] OP_WR_SYSTEM = 4'd9;
	localparam logic [3:0] OP_RESET     = 4'd10;

	// Configuration register indexes.
	localparam logic [2:0] CFG_WRITE_PROTECT = 3'd0;
	localparam logic [2:0] CFG_DISK_PRESENT  = 3'd1;
	localparam logic [2:0] CFG_DRIVE_READY   = 3'd2;
	localparam logic [2:0] CFG_ADDR_TRACK    = 3'd3;
	localparam logic [2:0] CFG_FORMAT_LENGTH = 3'd4;

	// Command codes (upper nibble of the command byte).
	localparam logic [3:0] CMD_RESTORE   = 4'h0;
	localparam logic [3:0] CMD_SEEK      = 4'h1;
	localparam logic [3:0] CMD_STEP      = 4'h2;
	localparam logic [3:0] CMD_STEP_U    = 4'h3;
	localparam logic [3:0] CMD_STEP_IN   = 4'h4;
	localparam logic [3:0] CMD_STEP_IN_U = 4'h5;
	localparam logic [3:0] CMD_STEP_OUT  = 4'h6;
	localparam logic [3:0] CMD_STEP_OUTU = 4'h7;
	localparam logic [3:0] CMD_RD_SEC    = 4'h8;
	localparam logic [3:0] CMD_RD_SEC_M  = 4'h9;
	localparam logic [3:0] CMD_WR_SEC    = 4'hA;
	localparam logic [3:0] CMD_WR_SEC_M  = 4'hB;
	localparam logic [3:0] CMD_RD_ADDR   = 4'hC;
	localparam logic [3:0] CMD_FORCE_IRQ = 4'hD;
	localparam logic [3:0] CMD_FORMAT    = 4'hF;

	// Status values.
	localparam logic [7:0] STAT_RESET     = 8'h24;
	localparam logic [7:0] STAT_BUSY      = 8'h03;
	localparam logic [7:0] STAT_NOT_READY = 8'h01;
	localparam logic [7:0] STAT_LOST      = 8'h04;
	localparam logic [7:0] STAT_TRACK0    = 8'h04;
	localparam logic [7:0] STAT_OUTSIDE   = 8'h08;
	localparam logic [7:0] STAT_NOT_FOUND = 8'h10;
	localparam logic [7:0] STAT_HEAD_LOAD = 8'h20;
	localparam logic [7:0] STAT_PROTECT   = 8'h40;
	localparam logic [7:0] STAT_IDLE      = 8'h00;

	// Interrupt line readback.
	localparam logic [7:0] IRQ_IDLE = 8'hBF;
	localparam logic [7:0] IRQ_BUSY = 8'h3F;
	localparam logic [7:0] IRQ_DRQ  = 8'h7F;

	localparam logic [7:0] SYSTEM_RESET = 8'h3C;
	localparam logic [7:0] TRACK_MAX    = 8'h4F;
	localparam logic [7:0] SECTOR_LAST  = 8'h10;
	localparam logic [4:0] COUNT_READY  = 5'd16;
	localparam logic [7:0] COUNT_LOST   = 8'h10;
	localparam logic [12:0] BYTE_COUNT_MAX = 13'h1FFF;

	// Bytes handed out by a read address command after the first one.
	function automatic logic [7:0] addr_byte(input logic [12:0] idx);
		logic [7:0] b;
		b = 8'h00;
		if (idx == 13'd1 || idx == 13'd2) begin
			b = 8'h01;
		end
		return b;
	endfunction

endpackage

// ===== rtl/fdc_ram.sv =====
module fdc_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/floppy_disk_controller_top.sv =====
// Register-level floppy disk controller.
// The host side is a request channel (in_valid/in_stall) carrying an access
// code and a write byte, and a result channel (out_valid/out_stall) carrying
// the byte read and the status register after the access. Every request
// gives exactly one result. The user must write the configuration registers
// (cfg_valid/cfg_ready/cfg_index/cfg_data) only while the block is idle; the
// block itself does not enforce this. Register accesses give their result in
// the cycle after acceptance. A data read during a sector transfer passes
// through a fetch state that reads the next byte from the sector buffer.
// Starting a sector read, or finishing a sector write, copies the sector byte
// by byte between disk store and sector buffer. Finishing a format clears,
// one byte per cycle, 5 * SECTOR_BYTES bytes of the disk store from the first
// sector of the track, or 0xA00 * 0x100 bytes from address zero with no image
// mounted. One request is worked on at a time; the next one is taken once the
// result register is free or is being emptied. After reset the disk store is
// cleared in a pass over all DISK_BYTES bytes while in_stall stays high;
// configuration writes are still taken. A result stalled by out_stall is held.
module floppy_disk_controller_top #(
	parameter int SECTOR_BYTES = fdc_pkg::SECTOR_BYTES_DEF,
	parameter int DISK_BYTES   = fdc_pkg::DISK_BYTES_DEF,
	parameter int DRIVES       = fdc_pkg::DRIVES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  operation,
	input  logic [7:0]  data_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  data_out,
	output logic [7:0]  status_now,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	import fdc_pkg::*;

	localparam int BW        = $clog2(SECTOR_BYTES);
	localparam int AW        = $clog2(DISK_BYTES);
	localparam int DW        = (DRIVES > 1) ? $clog2(DRIVES) : 1;
	localparam int UNIT_MAX  = 255 * 10 + 5 + 255;
	localparam int UW        = $clog2(UNIT_MAX + 1);
	localparam int POS_MAX   = (UNIT_MAX + 1) * SECTOR_BYTES + BLANK_BYTES + DISK_BYTES;
	localparam int PW        = $clog2(POS_MAX + 1);
	localparam int SWEEP_MAX = DISK_BYTES + BLANK_BYTES;
	localparam int CW        = $clog2(SWEEP_MAX + 1);
	localparam int FMT_LEN   = 5 * SECTOR_BYTES;
	localparam int BLANK_LEN = (BLANK_BYTES < DISK_BYTES) ? BLANK_BYTES : DISK_BYTES;

	typedef enum logic [2:0] {
		ST_INIT, ST_IDLE, ST_FETCH, ST_COPYR, ST_COPYW, ST_CLEAR
	} state_t;

	typedef enum logic [2:0] {
		JOB_NONE, JOB_FETCH, JOB_COPYR, JOB_COPYW, JOB_CLEAR
	} job_t;

	state_t state_q;

	// Configuration.
	logic        wp_q, dp_q, rdy_q, art_q;
	logic [12:0] fmt_len_q;

	// Controller registers.
	logic [7:0]  status_q, command_q, track_q, sector_q, data_q, system_q;
	logic [6:0]  head_q [DRIVES];
	logic        step_out_q;
	logic [12:0] bc_q, ts_q;
	logic [7:0]  lost_q, index_q;
	logic [4:0]  ready_q;

	// Result register.
	logic        out_valid_q;
	logic [7:0]  data_out_q, status_now_q;
	logic        out_set;

	// Sweep control for copies and clears.
	logic [CW-1:0] sweep_n_q, sweep_last_q, n_s1;
	logic          sweep_on_q, v_s1;
	logic [PW-1:0] pos_q, start_q;

	// Next values of one access.
	logic [7:0]    nx_status, nx_command, nx_track, nx_sector, nx_data, nx_system;
	logic [7:0]    nx_lost, nx_index, nx_res;
	logic [4:0]    nx_ready;
	logic [12:0]   nx_bc, nx_ts;
	logic          nx_step_out, nx_hwe;
	logic [7:0]    nx_hval;
	job_t          nx_job;
	logic [PW-1:0] nx_pos, nx_start;
	logic [CW-1:0] nx_len;
	logic          acc_buf_we;
	logic [BW-1:0] acc_buf_addr, acc_fetch_addr;

	// Memory ports.
	logic          disk_we, buf_we;
	logic [AW-1:0] disk_waddr, disk_raddr;
	logic [BW-1:0] buf_waddr, buf_raddr;
	logic [7:0]    disk_wdata, disk_rdata, buf_wdata, buf_rdata;

	logic          accept;
	logic [DW-1:0] drv;

	function automatic logic [PW-1:0] pos_of(input logic [7:0] trk, input logic side,
		input logic [7:0] s);
		logic [UW-1:0] u;
		u = UW'(trk) * UW'(10) + (side ? UW'(5) : UW'(0)) + UW'(s) - UW'(1);
		return PW'(u) * PW'(SECTOR_BYTES);
	endfunction

	function automatic logic pos_fits(input logic [7:0] s, input logic [PW-1:0] p);
		return (s != 8'd0) &&
			({1'b0, p} + (PW+1)'(SECTOR_BYTES) <= (PW+1)'(DISK_BYTES));
	endfunction

	// Drive number from the select bits, folded into the drive count.
	function automatic logic [DW-1:0] drive_of(input logic [1:0] sel);
		logic [2:0] v;
		v = {1'b0, sel};
		for (int k = 0; k < 3; k++) begin
			if (v >= 3'(DRIVES)) v = v - 3'(DRIVES);
		end
		return DW'(v);
	endfunction

	assign drv       = drive_of(system_q[1:0]);
	assign in_stall  = (state_q != ST_IDLE) || (out_valid_q && out_stall);
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// Effect of one access on the controller registers.
	always_comb begin
		logic f_sin, f_sout, f_end, f_srd, f_swr, f_beg, miss;
		logic [12:0] bsize;
		logic [12:0] idx;
		logic [PW-1:0] p;
		f_sin = 1'b0; f_sout = 1'b0; f_end = 1'b0;
		f_srd = 1'b0; f_swr = 1'b0; f_beg = 1'b0;
		bsize = 13'd0;
		idx = 13'd0;
		p = '0;
		miss = 1'b0;

		nx_status = status_q; nx_command = command_q; nx_track = track_q;
		nx_sector = sector_q; nx_data = data_q; nx_system = system_q;
		nx_lost = lost_q; nx_index = index_q; nx_ready = ready_q;
		nx_bc = bc_q; nx_ts = ts_q; nx_step_out = step_out_q;
		nx_hwe = 1'b0; nx_hval = 8'd0; nx_res = 8'd0;
		nx_job = JOB_NONE; nx_pos = '0; nx_start = '0; nx_len = '0;
		acc_buf_we = 1'b0; acc_buf_addr = BW'(bc_q); acc_fetch_addr = '0;

		// Countdowns run ahead of every access.
		if (nx_status[0]) begin
			nx_lost = nx_lost - 8'd1;
			if (nx_lost == 8'd0) begin
				nx_status = STAT_LOST;
			end
		end
		if (nx_ready != 5'd0) begin
			nx_ready = nx_ready - 5'd1;
			if (nx_ready == 5'd0) begin
				nx_status = STAT_BUSY;
			end
		end

		unique case (operation)
			OP_RD_STATUS: begin
				nx_res = nx_status;
				if (!command_q[7]) begin
					nx_index = nx_index - 8'd1;
					if (nx_index[3:1] != 3'd0) begin
						nx_res[1] = 1'b1;
					end
				end
			end
			OP_WR_CMD: begin
				if (!nx_status[0] && data_in[7:4] != CMD_FORCE_IRQ) begin
					nx_command = data_in;
					unique case (data_in[7:4])
						CMD_RESTORE: begin
							nx_track = 8'd0;
							nx_hwe = 1'b1;
							nx_hval = 8'd0;
							nx_step_out = 1'b1;
							f_end = 1'b1;
						end
						CMD_SEEK: begin
							if (data_q < track_q) nx_step_out = 1'b1;
							if (data_q > track_q) nx_step_out = 1'b0;
							nx_track = data_q;
							nx_hwe = 1'b1;
							nx_hval = data_q;
							f_end = 1'b1;
						end
						CMD_STEP, CMD_STEP_U: begin
							if (step_out_q) f_sout = 1'b1;
							else f_sin = 1'b1;
						end
						CMD_STEP_IN, CMD_STEP_IN_U: f_sin = 1'b1;
						CMD_STEP_OUT, CMD_STEP_OUTU: f_sout = 1'b1;
						CMD_RD_SEC, CMD_RD_SEC_M: f_srd = 1'b1;
						CMD_WR_SEC, CMD_WR_SEC_M: f_swr = 1'b1;
						CMD_RD_ADDR: begin
							nx_data = art_q ? track_q : 8'd1;
							f_beg = 1'b1;
							bsize = 13'd5;
						end
						CMD_FORMAT: begin
							if (wp_q) begin
								nx_status = STAT_PROTECT;
							end else begin
								f_beg = 1'b1;
								bsize = fmt_len_q;
							end
						end
						default: ;
					endcase
				end
			end
			OP_RD_TRACK: nx_res = track_q;
			OP_WR_TRACK: if (!nx_status[0]) nx_track = data_in;
			OP_RD_SECTOR: nx_res = sector_q;
			OP_WR_SECTOR: if (!nx_status[0]) nx_sector = data_in;
			OP_RD_DATA: begin
				if (!nx_status[0]) begin
					nx_res = data_q;
				end else if (command_q[7:4] == CMD_RD_SEC ||
					command_q[7:4] == CMD_RD_SEC_M) begin
					nx_res = data_q;
					nx_lost = COUNT_LOST;
					if (bc_q < ts_q) begin
						idx = bc_q + 13'd1;
						if (idx < 13'(SECTOR_BYTES)) begin
							nx_job = JOB_FETCH;
							acc_fetch_addr = BW'(idx);
						end else begin
							nx_data = 8'd0;
						end
						nx_bc = idx;
					end else if (command_q[4]) begin
						nx_sector = sector_q + 8'd1;
						f_srd = 1'b1;
					end else begin
						nx_status = STAT_IDLE;
					end
				end else if (command_q[7:4] == CMD_RD_ADDR) begin
					nx_res = data_q;
					nx_lost = COUNT_LOST;
					if (bc_q < ts_q) begin
						nx_data = addr_byte(bc_q);
						nx_bc = bc_q + 13'd1;
					end else begin
						nx_status = STAT_IDLE;
					end
				end
			end
			OP_WR_DATA: begin
				if (!nx_status[0]) begin
					nx_data = data_in;
				end else if (command_q[7:4] == CMD_WR_SEC ||
					command_q[7:4] == CMD_WR_SEC_M) begin
					acc_buf_we = bc_q < 13'(SECTOR_BYTES);
					nx_data = data_in;
					nx_lost = COUNT_LOST;
					nx_bc = (bc_q < BYTE_COUNT_MAX) ? bc_q + 13'd1 : bc_q;
					if (nx_bc >= ts_q) begin
						p = pos_of(track_q, system_q[4], sector_q);
						if (!pos_fits(sector_q, p)) begin
							nx_status = STAT_OUTSIDE;
						end else begin
							nx_job = JOB_COPYW;
							nx_pos = p;
							if (command_q[4]) begin
								nx_sector = sector_q + 8'd1;
								f_swr = 1'b1;
							end else begin
								nx_status = STAT_IDLE;
							end
						end
					end
				end else if (command_q[7:4] == CMD_FORMAT) begin
					nx_data = data_in;
					nx_lost = COUNT_LOST;
					nx_bc = (bc_q < BYTE_COUNT_MAX) ? bc_q + 13'd1 : bc_q;
					if (nx_bc >= ts_q) begin
						nx_job = JOB_CLEAR;
						if (dp_q) begin
							nx_start = pos_of(track_q, system_q[4], 8'd1);
							nx_len = CW'(FMT_LEN);
						end else begin
							nx_start = '0;
							nx_len = CW'(BLANK_LEN);
						end
						nx_status = STAT_IDLE;
					end
				end
			end
			OP_RD_IRQ: begin
				nx_res = IRQ_IDLE;
				if (nx_status[0]) nx_res = IRQ_BUSY;
				if (nx_status[1]) nx_res = IRQ_DRQ;
			end
			OP_WR_SYSTEM: begin
				if (nx_status[0] && command_q[7]) nx_status = STAT_OUTSIDE;
				else nx_system = data_in;
			end
			OP_RESET: begin
				nx_status = STAT_RESET;
				nx_command = 8'd0;
				nx_track = 8'd0;
				nx_sector = 8'd1;
				nx_data = 8'd0;
				nx_system = SYSTEM_RESET;
				nx_step_out = 1'b1;
			end
			default: ;
		endcase

		// Head steps.
		if (f_sin) begin
			nx_track = (track_q >= TRACK_MAX) ? TRACK_MAX : track_q + 8'd1;
			nx_hwe = 1'b1;
			nx_hval = nx_track;
			nx_step_out = 1'b0;
			f_end = 1'b1;
		end
		if (f_sout) begin
			if (track_q != 8'd0) begin
				nx_track = track_q - 8'd1;
				nx_hwe = 1'b1;
				nx_hval = nx_track;
			end
			nx_step_out = 1'b1;
			f_end = 1'b1;
		end
		if (f_end) begin
			if (nx_track > TRACK_MAX) begin
				nx_track = TRACK_MAX;
				nx_hwe = 1'b1;
				nx_hval = TRACK_MAX;
			end
			nx_status = wp_q ? STAT_PROTECT : STAT_IDLE;
			nx_ready = COUNT_READY;
			if (nx_command[3]) nx_status = nx_status | STAT_HEAD_LOAD;
			if (nx_track == 8'd0) nx_status = nx_status | STAT_TRACK0;
		end

		// Sector checks for starting a read or write.
		miss = nx_sector == 8'd0 || nx_sector > SECTOR_LAST ||
			nx_track != {1'b0, head_q[drv]} || !dp_q;
		if (f_srd) begin
			p = pos_of(nx_track, system_q[4], nx_sector);
			if (miss) begin
				nx_status = STAT_NOT_FOUND;
			end else if (!pos_fits(nx_sector, p)) begin
				nx_status = STAT_OUTSIDE;
			end else begin
				nx_job = JOB_COPYR;
				nx_pos = p;
				f_beg = 1'b1;
				bsize = 13'(SECTOR_BYTES - 1);
			end
		end
		if (f_swr) begin
			if (wp_q) begin
				nx_status = STAT_PROTECT;
			end else if (miss) begin
				nx_status = STAT_NOT_FOUND;
			end else begin
				f_beg = 1'b1;
				bsize = 13'(SECTOR_BYTES);
			end
		end
		if (f_beg) begin
			nx_lost = 8'd0;
			nx_bc = 13'd0;
			nx_ts = bsize;
			nx_status = STAT_BUSY;
			if (!rdy_q) begin
				nx_status = STAT_NOT_READY;
				nx_ready = COUNT_READY;
			end
		end
	end

	// A result becomes ready when a plain access is taken or a longer job ends.
	assign out_set = (state_q == ST_IDLE && accept && nx_job == JOB_NONE) ||
		(state_q == ST_FETCH) ||
		((state_q == ST_COPYR || state_q == ST_COPYW) && v_s1 && n_s1 == sweep_last_q) ||
		(state_q == ST_CLEAR && sweep_n_q == sweep_last_q);

	// Disk store port selection.
	always_comb begin
		logic [PW-1:0] a;
		a = start_q + PW'(sweep_n_q);
		disk_we = 1'b0;
		disk_waddr = '0;
		disk_wdata = 8'd0;
		disk_raddr = AW'(pos_q + PW'(sweep_n_q));
		unique case (state_q)
			ST_INIT: begin
				disk_we = 1'b1;
				disk_waddr = AW'(sweep_n_q);
			end
			ST_CLEAR: begin
				disk_we = a < PW'(DISK_BYTES);
				disk_waddr = AW'(a);
			end
			ST_COPYW: begin
				disk_we = v_s1;
				disk_waddr = AW'(pos_q + PW'(n_s1));
				disk_wdata = buf_rdata;
			end
			default: ;
		endcase
	end

	// Sector buffer port selection.
	always_comb begin
		buf_we = 1'b0;
		buf_waddr = '0;
		buf_wdata = 8'd0;
		buf_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				buf_we = accept && operation == OP_WR_DATA && acc_buf_we;
				buf_waddr = acc_buf_addr;
				buf_wdata = data_in;
				buf_raddr = acc_fetch_addr;
			end
			ST_COPYR: begin
				buf_we = v_s1;
				buf_waddr = BW'(n_s1);
				buf_wdata = disk_rdata;
			end
			ST_CLEAR: begin
				buf_we = sweep_n_q < CW'(SECTOR_BYTES);
				buf_waddr = BW'(sweep_n_q);
			end
			ST_COPYW: buf_raddr = BW'(sweep_n_q);
			default: ;
		endcase
	end

	fdc_ram #(.DEPTH(DISK_BYTES), .WIDTH(8)) u_disk (
		.clk   (clk),
		.we    (disk_we),
		.waddr (disk_waddr),
		.wdata (disk_wdata),
		.raddr (disk_raddr),
		.rdata (disk_rdata)
	);

	fdc_ram #(.DEPTH(SECTOR_BYTES), .WIDTH(8)) u_buf (
		.clk   (clk),
		.we    (buf_we),
		.waddr (buf_waddr),
		.wdata (buf_wdata),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

	// Sequencer, controller registers and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			wp_q <= 1'b0;
			dp_q <= 1'b1;
			rdy_q <= 1'b1;
			art_q <= 1'b0;
			fmt_len_q <= 13'd1;
			status_q <= STAT_RESET;
			command_q <= 8'd0;
			track_q <= 8'd0;
			sector_q <= 8'd1;
			data_q <= 8'd0;
			system_q <= SYSTEM_RESET;
			for (int i = 0; i < DRIVES; i++) head_q[i] <= 7'd0;
			step_out_q <= 1'b1;
			bc_q <= 13'd0;
			ts_q <= 13'd0;
			lost_q <= 8'd0;
			ready_q <= 5'd0;
			index_q <= 8'd0;
			out_valid_q <= 1'b0;
			data_out_q <= 8'd0;
			status_now_q <= 8'd0;
			sweep_n_q <= '0;
			sweep_last_q <= CW'(DISK_BYTES - 1);
			sweep_on_q <= 1'b0;
			n_s1 <= '0;
			v_s1 <= 1'b0;
			pos_q <= '0;
			start_q <= '0;
		end else begin
			// Configuration writes.
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_WRITE_PROTECT: wp_q <= cfg_data[0];
					CFG_DISK_PRESENT:  dp_q <= cfg_data[0];
					CFG_DRIVE_READY:   rdy_q <= cfg_data[0];
					CFG_ADDR_TRACK:    art_q <= cfg_data[0];
					CFG_FORMAT_LENGTH: fmt_len_q <= cfg_data;
					default: ;
				endcase
			end

			// Result valid is raised when a result is ready and dropped once taken.
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			v_s1 <= sweep_on_q;
			n_s1 <= sweep_n_q;

			unique case (state_q)
				ST_INIT: begin
					sweep_n_q <= sweep_n_q + CW'(1);
					if (sweep_n_q == sweep_last_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						status_q <= nx_status;
						command_q <= nx_command;
						track_q <= nx_track;
						sector_q <= nx_sector;
						data_q <= nx_data;
						system_q <= nx_system;
						if (nx_hwe) head_q[drv] <= nx_hval[6:0];
						step_out_q <= nx_step_out;
						bc_q <= nx_bc;
						ts_q <= nx_ts;
						lost_q <= nx_lost;
						ready_q <= nx_ready;
						index_q <= nx_index;
						data_out_q <= nx_res;
						status_now_q <= nx_status;
						pos_q <= nx_pos;
						start_q <= nx_start;
						sweep_n_q <= '0;
						unique case (nx_job)
							JOB_FETCH: state_q <= ST_FETCH;
							JOB_COPYR: begin
								state_q <= ST_COPYR;
								sweep_on_q <= 1'b1;
								sweep_last_q <= CW'(SECTOR_BYTES - 1);
							end
							JOB_COPYW: begin
								state_q <= ST_COPYW;
								sweep_on_q <= 1'b1;
								sweep_last_q <= CW'(SECTOR_BYTES - 1);
							end
							JOB_CLEAR: begin
								state_q <= ST_CLEAR;
								sweep_last_q <= nx_len - CW'(1);
							end
							default: ;
						endcase
					end
				end
				ST_FETCH: begin
					data_q <= buf_rdata;
					state_q <= ST_IDLE;
				end
				ST_COPYR, ST_COPYW: begin
					if (sweep_on_q) begin
						sweep_n_q <= sweep_n_q + CW'(1);
						if (sweep_n_q == sweep_last_q) sweep_on_q <= 1'b0;
					end
					if (state_q == ST_COPYR && v_s1 && n_s1 == '0) begin
						data_q <= disk_rdata;
					end
					if (v_s1 && n_s1 == sweep_last_q) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CLEAR: begin
					sweep_n_q <= sweep_n_q + CW'(1);
					if (sweep_n_q == sweep_last_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign data_out   = data_out_q;
	assign status_now = status_now_q;

endmodule

// ===== tb/floppy_disk_controller_top_tb.sv =====
module floppy_disk_controller_top_tb;
	import fdc_pkg::*;

	localparam int SEC_BYTES  = SECTOR_BYTES_DEF;
	localparam int IMG_BYTES  = DISK_BYTES_DEF;
	localparam int NUM_DRIVES = DRIVES_DEF;
	localparam int IDLE_LIMIT = 5000000;
	localparam logic [3:0] OP_SPARE_LO = 4'd11;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;

	typedef struct packed {
		logic [7:0] rd_byte;
		logic [7:0] status;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [3:0]  operation;
	logic [7:0]  data_in;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  data_out;
	logic [7:0]  status_now;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_index;
	logic [12:0] cfg_data;

	floppy_disk_controller_top i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.operation(operation), .data_in(data_in),
		.out_valid(out_valid), .out_stall(out_stall),
		.data_out(data_out), .status_now(status_now),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// Clock with a 12 unit period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Shadow copy of the controller: settings, registers and the disk image.
	bit         sh_protect, sh_present, sh_ready, sh_addr_track;
	bit [12:0]  sh_fmt_len;
	bit [7:0]   sh_status, sh_cmd, sh_track, sh_sector, sh_data, sh_system;
	bit [7:0]   sh_head [NUM_DRIVES];
	bit         sh_outward;
	bit [12:0]  sh_count, sh_size;
	bit [7:0]   sh_lost, sh_index;
	bit [4:0]   sh_ready_cnt;
	bit [7:0]   sh_buf [SEC_BYTES];
	bit [7:0]   sh_disk [IMG_BYTES];

	reply_t expected_replies[$];
	int     mismatches = 0;
	int     idle_cycles = 0;
	int     burst_left;

	function automatic int unsigned drive_sel();
		return (sh_system & 8'h03) % NUM_DRIVES;
	endfunction

	function automatic int unsigned track_start();
		return int'(sh_track) * SEC_BYTES * 10 + (sh_system[4] ? SEC_BYTES * 5 : 0);
	endfunction

	// Byte offset of a sector in pos; returns zero when the sector does not fit the image.
	function automatic bit sector_offset(input bit [7:0] s, output int unsigned pos);
		pos = 0;
		if (s == 8'd0) begin
			return 1'b0;
		end
		pos = track_start() + (int'(s) - 1) * SEC_BYTES;
		return pos + SEC_BYTES <= IMG_BYTES;
	endfunction

	function automatic void wipe_image(input int unsigned start, input int unsigned len);
		for (int unsigned i = 0; i < len; i++) begin
			if (start + i < IMG_BYTES) begin
				sh_disk[start + i] = 8'h00;
			end
		end
	endfunction

	function automatic void open_transfer(input bit [12:0] size);
		sh_lost   = 8'd0;
		sh_count  = 13'd0;
		sh_size   = size;
		sh_status = STAT_BUSY;
		if (!sh_ready) begin
			sh_status    = STAT_NOT_READY;
			sh_ready_cnt = COUNT_READY;
		end
	endfunction

	function automatic bit sector_absent();
		return sh_sector == 8'd0 || sh_sector > SECTOR_LAST ||
			sh_track != sh_head[drive_sel()] || !sh_present;
	endfunction

	function automatic void open_read();
		int unsigned pos;
		if (sector_absent()) begin
			sh_status = STAT_NOT_FOUND;
			return;
		end
		if (!sector_offset(sh_sector, pos)) begin
			sh_status = STAT_OUTSIDE;
			return;
		end
		for (int i = 0; i < SEC_BYTES; i++) begin
			sh_buf[i] = sh_disk[pos + i];
		end
		sh_data = sh_buf[0];
		open_transfer(13'(SEC_BYTES - 1));
	endfunction

	function automatic void open_write();
		if (sh_protect) begin
			sh_status = STAT_PROTECT;
			return;
		end
		if (sector_absent()) begin
			sh_status = STAT_NOT_FOUND;
			return;
		end
		open_transfer(13'(SEC_BYTES));
	endfunction

	function automatic void finish_step();
		if (sh_track > TRACK_MAX) begin
			sh_track = TRACK_MAX;
			sh_head[drive_sel()] = TRACK_MAX;
		end
		sh_status    = sh_protect ? STAT_PROTECT : STAT_IDLE;
		sh_ready_cnt = COUNT_READY;
		if (sh_cmd[3]) begin
			sh_status |= STAT_HEAD_LOAD;
		end
		if (sh_track == 8'd0) begin
			sh_status |= STAT_TRACK0;
		end
	endfunction

	function automatic void move_in();
		sh_track = (sh_track >= TRACK_MAX) ? TRACK_MAX : sh_track + 8'd1;
		sh_head[drive_sel()] = sh_track;
		sh_outward = 1'b0;
		finish_step();
	endfunction

	function automatic void move_out();
		if (sh_track != 8'd0) begin
			sh_track--;
			sh_head[drive_sel()] = sh_track;
		end
		sh_outward = 1'b1;
		finish_step();
	endfunction

	function automatic void take_command(input bit [7:0] v);
		if (sh_status[0] || v[7:4] == CMD_FORCE_IRQ) begin
			return;
		end
		sh_cmd = v;
		case (v[7:4])
			CMD_RESTORE: begin
				sh_track = 8'd0;
				sh_head[drive_sel()] = 8'd0;
				sh_outward = 1'b1;
				finish_step();
			end
			CMD_SEEK: begin
				if (sh_data < sh_track) sh_outward = 1'b1;
				if (sh_data > sh_track) sh_outward = 1'b0;
				sh_track = sh_data;
				sh_head[drive_sel()] = sh_data;
				finish_step();
			end
			CMD_STEP, CMD_STEP_U: begin
				if (sh_outward) move_out();
				else move_in();
			end
			CMD_STEP_IN, CMD_STEP_IN_U: move_in();
			CMD_STEP_OUT, CMD_STEP_OUTU: move_out();
			CMD_RD_SEC, CMD_RD_SEC_M: open_read();
			CMD_WR_SEC, CMD_WR_SEC_M: open_write();
			CMD_RD_ADDR: begin
				sh_data = sh_addr_track ? sh_track : 8'd1;
				open_transfer(13'd5);
			end
			CMD_FORMAT: begin
				if (sh_protect) sh_status = STAT_PROTECT;
				else open_transfer(sh_fmt_len);
			end
			default: ;
		endcase
	endfunction

	function automatic bit [7:0] fetch_data();
		bit [7:0] rd;
		int unsigned i;
		rd = 8'd0;
		if (!sh_status[0]) begin
			return sh_data;
		end
		if (sh_cmd[7:4] == CMD_RD_SEC || sh_cmd[7:4] == CMD_RD_SEC_M) begin
			rd = sh_data;
			sh_lost = COUNT_LOST;
			if (sh_count < sh_size) begin
				i = sh_count + 1;
				sh_data = (i < SEC_BYTES) ? sh_buf[i] : 8'd0;
				sh_count++;
			end else if (sh_cmd[4]) begin
				sh_sector++;
				open_read();
			end else begin
				sh_status = STAT_IDLE;
			end
		end else if (sh_cmd[7:4] == CMD_RD_ADDR) begin
			rd = sh_data;
			sh_lost = COUNT_LOST;
			if (sh_count < sh_size) begin
				sh_data = (sh_count == 13'd1 || sh_count == 13'd2) ? 8'd1 : 8'd0;
				sh_count++;
			end else begin
				sh_status = STAT_IDLE;
			end
		end
		return rd;
	endfunction

	function automatic void store_data(input bit [7:0] v);
		int unsigned pos;
		if (!sh_status[0]) begin
			sh_data = v;
			return;
		end
		if (sh_cmd[7:4] == CMD_WR_SEC || sh_cmd[7:4] == CMD_WR_SEC_M) begin
			if (sh_count < SEC_BYTES) sh_buf[sh_count] = v;
			sh_data = v;
			sh_lost = COUNT_LOST;
			if (sh_count != BYTE_COUNT_MAX) sh_count++;
			if (sh_count >= sh_size) begin
				if (!sector_offset(sh_sector, pos)) begin
					sh_status = STAT_OUTSIDE;
					return;
				end
				for (int i = 0; i < SEC_BYTES; i++) begin
					sh_disk[pos + i] = sh_buf[i];
				end
				if (sh_cmd[4]) begin
					sh_sector++;
					open_write();
				end else begin
					sh_status = STAT_IDLE;
				end
			end
		end else if (sh_cmd[7:4] == CMD_FORMAT) begin
			sh_data = v;
			sh_lost = COUNT_LOST;
			if (sh_count != BYTE_COUNT_MAX) sh_count++;
			if (sh_count >= sh_size) begin
				for (int i = 0; i < SEC_BYTES; i++) begin
					sh_buf[i] = 8'h00;
				end
				if (sh_present) wipe_image(track_start(), 5 * SEC_BYTES);
				else wipe_image(0, BLANK_BYTES);
				sh_status = STAT_IDLE;
			end
		end
	endfunction

	function automatic void soft_reset();
		sh_status  = STAT_RESET;
		sh_cmd     = 8'd0;
		sh_track   = 8'd0;
		sh_sector  = 8'd1;
		sh_data    = 8'd0;
		sh_system  = SYSTEM_RESET;
		sh_outward = 1'b1;
	endfunction

	function automatic void power_on();
		sh_protect = 1'b0;
		sh_present = 1'b1;
		sh_ready = 1'b1;
		sh_addr_track = 1'b0;
		sh_fmt_len = 13'd1;
		soft_reset();
		foreach (sh_head[d]) sh_head[d] = 8'd0;
		sh_count = 13'd0;
		sh_size = 13'd0;
		sh_lost = 8'd0;
		sh_ready_cnt = 5'd0;
		sh_index = 8'd0;
		foreach (sh_buf[i]) sh_buf[i] = 8'h00;
		foreach (sh_disk[i]) sh_disk[i] = 8'h00;
	endfunction

	// Expected reply of one bus access.
	function automatic reply_t predict_access(input bit [3:0] op, input bit [7:0] v);
		reply_t r;
		r.rd_byte = 8'd0;
		if (sh_status[0]) begin
			sh_lost--;
			if (sh_lost == 8'd0) sh_status = STAT_LOST;
		end
		if (sh_ready_cnt != 5'd0) begin
			sh_ready_cnt--;
			if (sh_ready_cnt == 5'd0) sh_status = STAT_BUSY;
		end
		case (op)
			OP_RD_STATUS: begin
				r.rd_byte = sh_status;
				if (!sh_cmd[7]) begin
					sh_index--;
					if (sh_index[3:1] != 3'd0) r.rd_byte[1] = 1'b1;
				end
			end
			OP_WR_CMD:    take_command(v);
			OP_RD_TRACK:  r.rd_byte = sh_track;
			OP_WR_TRACK:  if (!sh_status[0]) sh_track = v;
			OP_RD_SECTOR: r.rd_byte = sh_sector;
			OP_WR_SECTOR: if (!sh_status[0]) sh_sector = v;
			OP_RD_DATA:   r.rd_byte = fetch_data();
			OP_WR_DATA:   store_data(v);
			OP_RD_IRQ: begin
				r.rd_byte = IRQ_IDLE;
				if (sh_status[0]) r.rd_byte = IRQ_BUSY;
				if (sh_status[1]) r.rd_byte = IRQ_DRQ;
			end
			OP_WR_SYSTEM: begin
				if (sh_status[0] && sh_cmd[7]) sh_status = STAT_OUTSIDE;
				else sh_system = v;
			end
			OP_RESET:     soft_reset();
			default: ;
		endcase
		r.status = sh_status;
		return r;
	endfunction

	// Send one request; the sender may idle between bursts of random length.
	task automatic send_request(input logic [3:0] op, input logic [7:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		in_valid  <= 1'b1;
		operation <= op;
		data_in   <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		expected_replies.push_back(predict_access(op, v));
		@(negedge clk);
	endtask

	// Drop valid and wait until every reply is back.
	task automatic drain();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_replies.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_setting(input logic [2:0] idx, input logic [12:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_WRITE_PROTECT: sh_protect = val[0];
			CFG_DISK_PRESENT:  sh_present = val[0];
			CFG_DRIVE_READY:   sh_ready = val[0];
			CFG_ADDR_TRACK:    sh_addr_track = val[0];
			CFG_FORMAT_LENGTH: sh_fmt_len = val;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic seek_to(input logic [7:0] trk);
		send_request(OP_WR_DATA, trk);
		send_request(OP_WR_CMD, {CMD_SEEK, 4'h0});
	endtask

	// Plain register traffic, interrupt lines, unused codes and index pulse.
	task automatic test_registers();
		send_request(OP_RD_STATUS, 8'h00);
		send_request(OP_RD_IRQ, 8'h00);
		send_request(OP_WR_TRACK, 8'hFF);
		send_request(OP_RD_TRACK, 8'h00);
		send_request(OP_WR_SECTOR, 8'h00);
		send_request(OP_RD_SECTOR, 8'hFF);
		send_request(OP_WR_DATA, 8'hA5);
		send_request(OP_RD_DATA, 8'h00);
		send_request(OP_WR_SYSTEM, 8'hFF);
		send_request(OP_SPARE_LO, 8'h5A);
		send_request(OP_SPARE_HI, 8'hFF);
		repeat (3) send_request(OP_RD_STATUS, 8'h00);
		send_request(OP_RESET, 8'h00);
	endtask

	// Restore, seeks to both ends, steps at the limits, head load, force interrupt.
	task automatic test_stepping();
		send_request(OP_WR_CMD, {CMD_RESTORE, 4'h8});
		send_request(OP_WR_CMD, {CMD_STEP_OUT, 4'h0});
		seek_to(8'hFF);
		send_request(OP_WR_CMD, {CMD_STEP_IN, 4'h8});
		send_request(OP_WR_CMD, {CMD_STEP, 4'h0});
		send_request(OP_WR_CMD, {CMD_FORCE_IRQ, 4'h0});
		seek_to(8'h00);
		send_request(OP_WR_CMD, {CMD_STEP_U, 4'h0});
		send_request(OP_RD_TRACK, 8'h00);
	endtask

	// Sector read start fills the whole buffer; then missing and outside sectors.
	task automatic test_sector_read();
		send_request(OP_RESET, 8'h00);
		send_request(OP_WR_CMD, {CMD_RESTORE, 4'h0});
		send_request(OP_WR_CMD, {CMD_RD_SEC, 4'h0});
		repeat (4) send_request(OP_RD_DATA, 8'h00);
		send_request(OP_WR_SYSTEM, 8'h00);
		repeat (18) send_request(OP_RD_STATUS, 8'h00);
		send_request(OP_WR_SECTOR, 8'h11);
		send_request(OP_WR_CMD, {CMD_RD_SEC, 4'h0});
		send_request(OP_WR_SECTOR, 8'h00);
		send_request(OP_WR_CMD, {CMD_RD_SEC_M, 4'h0});
		send_request(OP_WR_SYSTEM, 8'h10);
		seek_to(TRACK_MAX);
		send_request(OP_WR_SECTOR, SECTOR_LAST);
		send_request(OP_WR_CMD, {CMD_RD_SEC, 4'h0});
		send_request(OP_WR_CMD, {CMD_WR_SEC, 4'h0});
		repeat (4) send_request(OP_WR_DATA, 8'h3C);
	endtask

	// Read address with both first-byte choices.
	task automatic test_read_address();
		for (int k = 0; k < 2; k++) begin
			drain();
			write_setting(CFG_ADDR_TRACK, 13'(k));
			send_request(OP_RESET, 8'h00);
			seek_to(8'd7);
			send_request(OP_WR_CMD, {CMD_RD_ADDR, 4'h0});
			repeat (7) send_request(OP_RD_DATA, 8'h00);
			send_request(OP_RD_IRQ, 8'h00);
		end
	endtask

	// A full sector write, then a read of sector 1, with a multi-sector write left to run out.
	task automatic test_sector_write();
		logic [7:0] trk;
		trk = 8'($urandom_range(0, 78));
		send_request(OP_RESET, 8'h00);
		send_request(OP_WR_SYSTEM, 8'($urandom_range(0, 255)));
		seek_to(trk);
		send_request(OP_WR_SECTOR, 8'($urandom_range(1, 16)));
		send_request(OP_WR_CMD, {CMD_WR_SEC_M, 4'h0});
		repeat (SEC_BYTES + 3) send_request(OP_WR_DATA, 8'($urandom_range(0, 255)));
		repeat (20) send_request(OP_RD_STATUS, 8'h00);
		send_request(OP_WR_SECTOR, 8'd1);
		send_request(OP_WR_CMD, {CMD_RD_SEC, 4'h0});
		repeat (12) send_request(OP_RD_DATA, 8'h00);
	endtask

	// Format: protected, short, overlong aborted by data loss, and with no disk.
	task automatic test_format();
		drain();
		write_setting(CFG_WRITE_PROTECT, 13'd1);
		send_request(OP_RESET, 8'h00);
		send_request(OP_WR_CMD, {CMD_STEP_IN, 4'h0});
		send_request(OP_WR_CMD, {CMD_FORMAT, 4'h0});
		drain();
		write_setting(CFG_WRITE_PROTECT, 13'd0);
		write_setting(CFG_FORMAT_LENGTH, 13'd3);
		send_request(OP_RESET, 8'h00);
		send_request(OP_WR_CMD, {CMD_FORMAT, 4'h0});
		repeat (3) send_request(OP_WR_DATA, 8'hE5);
		send_request(OP_RD_STATUS, 8'h00);
		drain();
		write_setting(CFG_FORMAT_LENGTH, BYTE_COUNT_MAX);
		send_request(OP_WR_CMD, {CMD_FORMAT, 4'h0});
		repeat (3) send_request(OP_WR_DATA, 8'h00);
		repeat (18) send_request(OP_RD_IRQ, 8'h00);
		drain();
		write_setting(CFG_DISK_PRESENT, 13'd0);
		write_setting(CFG_FORMAT_LENGTH, 13'd1);
		send_request(OP_RESET, 8'h00);
		send_request(OP_WR_CMD, {CMD_RD_SEC, 4'h0});
		send_request(OP_WR_CMD, {CMD_FORMAT, 4'h0});
		send_request(OP_WR_DATA, 8'hFF);
		send_request(OP_RD_STATUS, 8'h00);
		drain();
		write_setting(CFG_DISK_PRESENT, 13'd1);
	endtask

	// Drive not ready: the command waits out the ready countdown.
	task automatic test_not_ready();
		drain();
		write_setting(CFG_DRIVE_READY, 13'd0);
		send_request(OP_RESET, 8'h00);
		send_request(OP_WR_CMD, {CMD_RD_SEC, 4'h0});
		repeat (18) send_request(OP_RD_STATUS, 8'h00);
		send_request(OP_RD_DATA, 8'h00);
		send_request(OP_WR_SYSTEM, 8'h01);
		drain();
		write_setting(CFG_DRIVE_READY, 13'd1);
	endtask

	// Random phases of command sequences with random contents and some noise.
	task automatic test_random();
		int done;
		int kind;
		for (int phase = 0; phase < 2; phase++) begin
			drain();
			write_setting(CFG_WRITE_PROTECT, 13'($urandom_range(0, 3) == 0));
			write_setting(CFG_DRIVE_READY, 13'($urandom_range(0, 3) != 0));
			write_setting(CFG_ADDR_TRACK, 13'($urandom_range(0, 1)));
			write_setting(CFG_FORMAT_LENGTH, 13'($urandom_range(1, 6)));
			done = 0;
			while (done < 40) begin
				kind = $urandom_range(0, 9);
				if ($urandom_range(0, 2) == 0) begin
					send_request(OP_RESET, 8'h00);
					done++;
				end
				case (kind)
					0, 1: begin
						repeat (4) send_request(4'($urandom_range(0, 15)),
							8'($urandom_range(0, 255)));
						done += 4;
					end
					2, 3, 4: begin
						send_request(OP_WR_SYSTEM, 8'($urandom_range(0, 255)));
						seek_to(8'($urandom_range(0, 90)));
						send_request(OP_WR_SECTOR, 8'($urandom_range(0, 17)));
						send_request(OP_WR_CMD, {($urandom_range(0, 1) ? CMD_RD_SEC_M
							: CMD_RD_SEC), 4'($urandom_range(0, 15))});
						repeat ($urandom_range(1, 30)) begin
							send_request(OP_RD_DATA, 8'h00);
							done++;
						end
						done += 5;
					end
					5: begin
						send_request(OP_WR_CMD, {CMD_RD_ADDR, 4'($urandom_range(0, 15))});
						repeat ($urandom_range(1, 8)) begin
							send_request(OP_RD_DATA, 8'h00);
							done++;
						end
						done++;
					end
					6, 7: begin
						send_request(OP_WR_CMD, {4'($urandom_range(0, 7)),
							4'($urandom_range(0, 15))});
						send_request(OP_RD_STATUS, 8'h00);
						done += 2;
					end
					8: begin
						send_request(OP_WR_CMD, {CMD_WR_SEC, 4'($urandom_range(0, 15))});
						repeat ($urandom_range(1, 10)) begin
							send_request(OP_WR_DATA, 8'($urandom_range(0, 255)));
							done++;
						end
						done++;
					end
					default: begin
						send_request(OP_WR_CMD, {CMD_FORMAT, 4'($urandom_range(0, 15))});
						repeat ($urandom_range(1, 7)) begin
							send_request(OP_WR_DATA, 8'($urandom_range(0, 255)));
							done++;
						end
						done++;
					end
				endcase
				repeat ($urandom_range(0, 20)) begin
					send_request(($urandom_range(0, 1) ? OP_RD_STATUS : OP_RD_IRQ), 8'h00);
					done++;
				end
			end
		end
	endtask

	// Result stall follows a pattern that switches between modes.
	int stall_mode = 0;
	int stall_left = 0;
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 3);
			stall_left = $urandom_range(10, 200);
		end
		stall_left--;
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			2: out_stall <= (stall_left % 8) < 5;
			default: out_stall <= ($urandom_range(0, 1) == 0);
		endcase
	end

	// Compare each result with the oldest expectation.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_replies.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected result: data_out %h status_now %h",
						data_out, status_now);
				end
			end else begin
				want = expected_replies.pop_front();
				if (data_out !== want.rd_byte || status_now !== want.status) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch: data_out %h (exp %h) status_now %h (exp %h)",
							data_out, want.rd_byte, status_now, want.status);
					end
				end
			end
		end
	end

	// Watchdog on cycles where no request, result or setting is accepted.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[floppy_disk_controller_top] ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n      = 1'b0;
		in_valid    = 1'b0;
		operation   = OP_RD_STATUS;
		data_in     = 8'h00;
		cfg_valid   = 1'b0;
		cfg_index   = CFG_WRITE_PROTECT;
		cfg_data    = 13'd0;
		burst_left  = 0;
		power_on();
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_registers();
		test_stepping();
		test_sector_read();
		test_read_address();
		test_sector_write();
		test_format();
		test_not_ready();
		test_random();

		drain();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && expected_replies.size() == 0) begin
			$display("[floppy_disk_controller_top] OK");
		end else begin
			$display("[floppy_disk_controller_top] ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/fdc_pkg.sv
rtl/fdc_ram.sv
rtl/floppy_disk_controller_top.sv
tb/floppy_disk_controller_top_tb.sv
